[src/lkv_pkg.sv]
// ----------------------------------------------------------------------------
// lkv_pkg
// Shared types and constants for the LRU key-value cache.
// ----------------------------------------------------------------------------
`default_nettype none

package lkv_pkg;

	localparam int CAPACITY    = 16;
	localparam int KEY_WIDTH   = 16;
	localparam int VALUE_WIDTH = 16;
	localparam int LIMIT_W     = 5;
	localparam int CNT_W       = $clog2(CAPACITY + 1);
	localparam int CMP_W       = (LIMIT_W > CNT_W) ? LIMIT_W : CNT_W;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(16);

	typedef enum logic {
		ACT_GET = 1'b0,
		ACT_PUT = 1'b1
	} action_t;

	typedef struct packed {
		logic                   valid;
		logic [KEY_WIDTH-1:0]   key;
		logic [VALUE_WIDTH-1:0] value;
	} entry_t;

endpackage

`default_nettype wire

[src/lkv_cell.sv]
// ----------------------------------------------------------------------------
// lkv_cell
// One recency slot: holds an entry, compares it against the lookup key and
// loads its neighbor's entry when the row shifts.
// ----------------------------------------------------------------------------
`default_nettype none

module lkv_cell
	import lkv_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 load,
	input  wire logic [KEY_WIDTH-1:0] lookup_key,
	input  wire entry_t               d,
	output entry_t                    q,
	output logic                      match
);

	logic                   valid_q;
	logic [KEY_WIDTH-1:0]   key_q;
	logic [VALUE_WIDTH-1:0] value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= d.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			key_q   <= d.key;
			value_q <= d.value;
		end
	end

	assign q.valid = valid_q;
	assign q.key   = key_q;
	assign q.value = value_q;
	assign match   = valid_q && (key_q == lookup_key);

endmodule

`default_nettype wire

[src/lru_key_value_cache_unit.sv]
// ----------------------------------------------------------------------------
// lru_key_value_cache_unit
// Fully associative key-value cache with least-recently-used replacement.
//
// Input beats carry a get or a put (s_tuser[0]) with key and value in s_tdata.
// Each get gives one output beat: m_tuser[0] is the hit flag and m_tdata the
// stored value, zero on a miss. A put gives no output beat.
// Entries sit in a row of cells ordered by recency, the most recent in cell 0.
// A hit moves its entry to the front while the younger cells shift down one;
// an insert enters at the front and pushes the row, dropping the last valid
// entry once the fill reaches capacity_limit (saturated to CAPACITY, zero
// treated as one).
// One beat is taken per cycle while s_tready is high; a get's result is
// registered and appears in the cycle after it is accepted. The per-cycle
// figure is set by the parallel key compare across all cells and the one-step shift of the row.
// Reset clears every valid bit and the fill count and sets the limit to 16.
// While an output beat waits on m_tready, s_tready drops until it is taken.
// The limit register is written whenever cfg_we is high.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_key_value_cache_unit
	import lkv_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_we,
	input  wire logic [LIMIT_W-1:0]     cfg_wdata,
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	input  wire logic [31:0]            s_tdata,  // key[15:0], value[31:16]
	input  wire logic [0:0]             s_tuser,  // action[0]
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	output logic [VALUE_WIDTH-1:0]      m_tdata,  // read_value[15:0]
	output logic [0:0]                  m_tuser   // found[0]
);

	logic [LIMIT_W-1:0]     cap_limit_q;
	logic [CNT_W-1:0]       count_q;
	logic                   out_valid_q;
	logic                   found_q;
	logic [VALUE_WIDTH-1:0] read_value_q;

	logic [KEY_WIDTH-1:0]   in_key;
	logic [VALUE_WIDTH-1:0] in_value;
	action_t                in_action;
	logic                   accept;

	entry_t                 cell_q    [CAPACITY];
	entry_t                 cell_d    [CAPACITY];
	logic [CAPACITY-1:0]    match;
	logic [CAPACITY-1:0]    seen;
	logic [CAPACITY-1:0]    load;
	logic                   hit;
	logic [VALUE_WIDTH-1:0] hit_value;
	logic [CMP_W-1:0]       lim_ext;
	logic [CNT_W-1:0]       eff_limit;
	logic                   evict;
	logic                   update;

	assign in_key    = s_tdata[KEY_WIDTH-1:0];
	assign in_value  = s_tdata[KEY_WIDTH+VALUE_WIDTH-1:KEY_WIDTH];
	assign in_action = action_t'(s_tuser[0]);
	assign s_tready  = !out_valid_q || m_tready;
	assign accept    = s_tvalid && s_tready;

	always_comb begin
		logic                   prefix;
		logic [VALUE_WIDTH-1:0] acc_value;
		prefix    = 1'b0;
		acc_value = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			seen[i]   = prefix;
			prefix    = prefix | match[i];
			acc_value = acc_value | ({VALUE_WIDTH{match[i]}} & cell_q[i].value);
		end
		hit       = prefix;
		hit_value = acc_value;
	end

	always_comb begin
		lim_ext = CMP_W'(cap_limit_q);
		if (lim_ext > CMP_W'(CAPACITY)) begin
			eff_limit = CNT_W'(CAPACITY);
		end else if (lim_ext == '0) begin
			eff_limit = CNT_W'(1);
		end else begin
			eff_limit = CNT_W'(lim_ext);
		end
	end

	assign evict  = (in_action == ACT_PUT) && !hit && (count_q >= eff_limit);
	assign update = accept && ((in_action == ACT_PUT) || hit);

	always_comb begin
		cell_d[0].valid = 1'b1;
		cell_d[0].key   = in_key;
		cell_d[0].value = (in_action == ACT_PUT) ? in_value : hit_value;
		load[0]         = update;
		for (int i = 1; i < CAPACITY; i++) begin
			cell_d[i] = cell_q[i-1];
			load[i]   = update && !seen[i] && (evict ? cell_q[i].valid : cell_q[i-1].valid);
		end
	end

	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		lkv_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.load       (load[g]),
			.lookup_key (in_key),
			.d          (cell_d[g]),
			.q          (cell_q[g]),
			.match      (match[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_limit_q <= LIMIT_RESET;
		end else if (cfg_we) begin
			cap_limit_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept && (in_action == ACT_PUT) && !hit && !evict) begin
			count_q <= count_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && (in_action == ACT_GET)) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (in_action == ACT_GET)) begin
			found_q      <= hit;
			read_value_q <= hit_value;
		end
	end

	assign m_tvalid   = out_valid_q;
	assign m_tdata    = read_value_q;
	assign m_tuser[0] = found_q;

endmodule

`default_nettype wire

[src/lkv_checker.sv]
// ----------------------------------------------------------------------------
// lkv_checker
// Port-level checks for the LRU key-value cache, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lkv_checker
	import lkv_pkg::*;
(
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   s_tvalid,
	input wire logic                   s_tready,
	input wire logic [31:0]            s_tdata,
	input wire logic [0:0]             s_tuser,
	input wire logic                   m_tvalid,
	input wire logic                   m_tready,
	input wire logic [VALUE_WIDTH-1:0] m_tdata,
	input wire logic [0:0]             m_tuser
);

	logic s_beat;
	logic out_stall;

	assign s_beat    = s_tvalid && s_tready;
	assign out_stall = m_tvalid && !m_tready;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_stall |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("output beat changed while stalled");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata == '0)
		else $error("miss carries nonzero data");

	a_get_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_beat && (s_tuser[0] == ACT_GET) |=> m_tvalid)
		else $error("get gave no result");

	a_put_silent: assert property (@(posedge clk) disable iff (!arst_n)
		s_beat && (s_tuser[0] == ACT_PUT) && !out_stall |=> !m_tvalid)
		else $error("put gave a result");

	a_put_then_hit: assert property (@(posedge clk) disable iff (!arst_n)
		s_beat && (s_tuser[0] == ACT_GET) && $past(s_beat && (s_tuser[0] == ACT_PUT))
		&& (s_tdata[KEY_WIDTH-1:0] == $past(s_tdata[KEY_WIDTH-1:0])) |=> m_tuser[0])
		else $error("get right after put of the same key missed");

endmodule

bind lru_key_value_cache_unit lkv_checker u_lkv_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

`default_nettype wire

[tb/lru_key_value_cache_unit_tb.sv]
// ----------------------------------------------------------------------------
// lru_key_value_cache_unit_tb
// Self-checking bench for the LRU key-value cache. A shadow copy of the store
// (keys, values, valid bits, recency ranks) predicts the lookup answer of
// every accepted get beat; answers leaving the block are checked in order.
// Stimulus runs directed corner cases, then random get/put traffic drawn
// from a small key pool over a series of capacity limits, with random
// back-pressure and input gaps on both streams.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_key_value_cache_unit_tb
	import lkv_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 200000;
	localparam int POOL_SIZE   = 24;

	typedef struct {
		logic                   found;
		logic [VALUE_WIDTH-1:0] read_value;
	} lookup_t;

	class cache_scoreboard;
		logic [KEY_WIDTH-1:0]   keys [CAPACITY];
		logic [VALUE_WIDTH-1:0] values [CAPACITY];
		bit                     valid [CAPACITY];
		int                     age [CAPACITY];
		logic [LIMIT_W-1:0]     limit;
		lookup_t                pending_lookups [$];
		int                     mismatches;

		function new();
			for (int i = 0; i < CAPACITY; i++) begin
				valid[i] = 1'b0;
				age[i]   = 0;
			end
			limit      = LIMIT_RESET;
			mismatches = 0;
		endfunction

		function void set_limit(logic [LIMIT_W-1:0] v);
			limit = v;
		endfunction

		function int pending();
			return pending_lookups.size();
		endfunction

		function int active_limit();
			int lim;
			lim = (limit > CAPACITY) ? CAPACITY : int'(limit);
			if (lim == 0)
				lim = 1;
			return lim;
		endfunction

		function void promote(int idx);
			int a;
			a = age[idx];
			for (int i = 0; i < CAPACITY; i++)
				if (valid[i] && i != idx && age[i] < a)
					age[i]++;
			age[idx] = 0;
		endfunction

		function void note_request(action_t act, logic [KEY_WIDTH-1:0] key,
				logic [VALUE_WIDTH-1:0] val);
			int      hit;
			int      fill;
			int      slot;
			int      oldest;
			lookup_t ans;
			hit = -1;
			for (int i = CAPACITY - 1; i >= 0; i--)
				if (valid[i] && keys[i] == key)
					hit = i;
			if (act == ACT_GET) begin
				if (hit >= 0) begin
					promote(hit);
					ans.found      = 1'b1;
					ans.read_value = values[hit];
				end else begin
					ans.found      = 1'b0;
					ans.read_value = '0;
				end
				pending_lookups.push_back(ans);
				return;
			end
			if (hit >= 0) begin
				values[hit] = val;
				promote(hit);
				return;
			end
			fill = 0;
			slot = CAPACITY;
			for (int i = 0; i < CAPACITY; i++) begin
				if (valid[i])
					fill++;
				else if (slot == CAPACITY)
					slot = i;
			end
			if (fill >= active_limit() || slot == CAPACITY) begin
				oldest = 0;
				slot   = 0;
				for (int i = 0; i < CAPACITY; i++)
					if (valid[i] && age[i] >= oldest) begin
						oldest = age[i];
						slot   = i;
					end
				valid[slot] = 1'b0;
			end
			for (int i = 0; i < CAPACITY; i++)
				if (valid[i])
					age[i]++;
			valid[slot]  = 1'b1;
			keys[slot]   = key;
			values[slot] = val;
			age[slot]    = 0;
		endfunction

		function void check_response(logic found, logic [VALUE_WIDTH-1:0] rd);
			lookup_t exp_ans;
			if (pending_lookups.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected output beat: found=%0b read_value=%h", found, rd);
				return;
			end
			exp_ans = pending_lookups.pop_front();
			if (found !== exp_ans.found || rd !== exp_ans.read_value) begin
				mismatches++;
				if (mismatches <= 10)
					$display("lookup mismatch: expected found=%0b value=%h, got %0b %h",
						exp_ans.found, exp_ans.read_value, found, rd);
			end
		endfunction
	endclass

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   cfg_we    = 1'b0;
	logic [LIMIT_W-1:0]     cfg_wdata = '0;
	logic                   s_tvalid  = 1'b0;
	logic                   s_tready;
	logic [31:0]            s_tdata   = '0;  // key[15:0], value[31:16]
	logic [0:0]             s_tuser   = '0;  // action[0]
	logic                   m_tvalid;
	logic                   m_tready  = 1'b0;
	logic [VALUE_WIDTH-1:0] m_tdata;         // read_value[15:0]
	logic [0:0]             m_tuser;         // found[0]

	cache_scoreboard      sb;
	int                   cycles        = 0;
	int                   rx_stall_left = 0;
	int                   rx_stall_pct  = 0;
	int                   tx_gap_pct    = 0;
	bit                   no_idle       = 1'b0;
	logic [KEY_WIDTH-1:0] key_pool [POOL_SIZE];

	lru_key_value_cache_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				sb.note_request(action_t'(s_tuser[0]), s_tdata[15:0], s_tdata[31:16]);
			if (m_tvalid && m_tready)
				sb.check_response(m_tuser[0], m_tdata);
		end
	end

	// hold m_tready low in bursts, started at random
	always @(negedge clk) begin
		if (!no_idle && rx_stall_left > 0) begin
			m_tready      <= 1'b0;
			rx_stall_left <= rx_stall_left - 1;
		end else if (!no_idle && $urandom_range(0, 99) < rx_stall_pct) begin
			m_tready      <= 1'b0;
			rx_stall_left <= $urandom_range(0, 4);
		end else begin
			m_tready <= 1'b1;
		end
	end

	task automatic send_request(action_t act, logic [KEY_WIDTH-1:0] key,
			logic [VALUE_WIDTH-1:0] val);
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser  <= act;
		s_tdata  <= {val, key};
		do
			@(posedge clk);
		while (!s_tready);
	endtask

	task automatic pause_input(int n);
		@(negedge clk);
		s_tvalid <= 1'b0;
		repeat (n - 1) @(negedge clk);
	endtask

	task automatic program_limit(logic [LIMIT_W-1:0] v);
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.set_limit(v);
	endtask

	function automatic logic [KEY_WIDTH-1:0] pick_key(int pool_n);
		if ($urandom_range(0, 9) == 0)
			return KEY_WIDTH'($urandom);
		return key_pool[$urandom_range(0, pool_n - 1)];
	endfunction

	task automatic run_traffic(logic [LIMIT_W-1:0] lim, int n_items);
		int      pool_n;
		action_t act;
		program_limit(lim);
		pool_n = sb.active_limit() + 4;
		if (pool_n > POOL_SIZE)
			pool_n = POOL_SIZE;
		for (int i = 0; i < n_items; i++) begin
			act = ($urandom_range(0, 99) < 45) ? ACT_PUT : ACT_GET;
			send_request(act, pick_key(pool_n), VALUE_WIDTH'($urandom));
			if (!no_idle && $urandom_range(0, 99) < tx_gap_pct)
				pause_input($urandom_range(1, 5));
		end
	endtask

	initial begin
		logic [LIMIT_W-1:0] limits [10];
		sb = new();
		for (int i = 0; i < POOL_SIZE; i++)
			key_pool[i] = KEY_WIDTH'($urandom);
		limits = '{5'd31, 5'd16, 5'd2, 5'd1, 5'd0, 5'd7, 5'd17, 5'd4, 5'd12, 5'd3};

		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		rx_stall_pct = 20;
		tx_gap_pct   = 20;

		// empty store, extremes of key and value, update in place
		send_request(ACT_GET, 16'h0000, 16'h0000);
		send_request(ACT_PUT, 16'h0000, 16'hFFFF);
		send_request(ACT_PUT, 16'hFFFF, 16'h0000);
		send_request(ACT_GET, 16'h0000, 16'h0000);
		send_request(ACT_GET, 16'hFFFF, 16'hFFFF);
		send_request(ACT_PUT, 16'h0000, 16'h1234);
		send_request(ACT_GET, 16'h0000, 16'h0000);
		send_request(ACT_GET, 16'h5555, 16'hFFFF);

		// zero limit acts as one entry
		program_limit(5'd0);
		send_request(ACT_PUT, 16'h00FF, 16'hAAAA);
		send_request(ACT_PUT, 16'hFF00, 16'h5555);
		send_request(ACT_GET, 16'h00FF, 16'h0000);
		send_request(ACT_GET, 16'hFF00, 16'h0000);

		foreach (limits[p]) begin
			rx_stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
			tx_gap_pct   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
			run_traffic(limits[p], 90);
		end

		no_idle = 1'b1;
		run_traffic(5'd16, 100);

		@(negedge clk);
		s_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

`default_nettype wire
